FILE: rtl/core/dual_frame_link_parser_defines.svh
// ----------------------------------------------------------------------------
// Dual frame link parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef DUAL_FRAME_LINK_PARSER_DEFINES_SVH
`define DUAL_FRAME_LINK_PARSER_DEFINES_SVH

// same-cycle implication
`define DFL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dfl_pkg.sv
// ----------------------------------------------------------------------------
// dfl_pkg
// Constants and controller/datapath interface types of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dfl_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;

  localparam logic [7:0] SOF_VALUE = 8'hAA;
  localparam logic [7:0] SOF_RESP  = 8'hB5;
  localparam logic [7:0] EOF_BYTE  = 8'hBB;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic v_start;    // measurement frame start: clear byte counter
    logic v_store;    // capture a value byte
    logic r_start;    // response frame start: clear count and sum
    logic r_cmd;      // capture command byte
    logic r_len;      // capture length byte
    logic r_data;     // write payload byte to store
    logic emit_meas;  // load measurement result
    logic emit_zero;  // load empty response result
    logic rd_start;   // clear payload read index
    logic rd_issue;   // read payload store at read index
    logic emit_load;  // load payload result from store data
  } dfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sof_v;      // incoming byte is a measurement start
    logic sof_r;      // incoming byte is a response start
    logic eof;        // incoming byte is an end byte
    logic v_chk_ok;   // incoming byte matches value checksum
    logic v_done;     // second value byte is arriving
    logic len_big;    // incoming length exceeds payload limit
    logic rx_zero;    // incoming byte is zero
    logic r_done;     // last payload byte is arriving
    logic r_chk_ok;   // incoming byte matches running sum
    logic len_zero;   // stored length is zero
    logic emit_last;  // read index is the final payload byte
    logic out_valid;  // result register holds a result
    logic out_free;   // result register can take a new result
  } dfl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dfl_ram.sv
// ----------------------------------------------------------------------------
// dfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dfl_ctrl.sv
// ----------------------------------------------------------------------------
// dfl_ctrl
// Frame phase state machine: decodes byte role and drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dfl_ctrl
  import dfl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dfl_stat_t stat,
  output dfl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_HUNT,
    S_V_DATA,
    S_V_CHK,
    S_V_EOF,
    S_R_CMD,
    S_R_LEN,
    S_R_DATA,
    S_R_CHK,
    S_R_EOF,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an end byte may produce a result, so it waits for an empty result register
  always_comb begin
    unique case (state_r)
      S_EMIT_RD, S_EMIT_LD: in_ready = 1'b0;
      S_V_EOF, S_R_EOF:     in_ready = !stat.out_valid;
      default:              in_ready = 1'b1;
    endcase
  end

  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_HUNT: begin
        if (acc) begin
          if (stat.sof_v) begin
            cmd.v_start = 1'b1;
            state_nxt   = S_V_DATA;
          end else if (stat.sof_r) begin
            cmd.r_start = 1'b1;
            state_nxt   = S_R_CMD;
          end
        end
      end
      S_V_DATA: begin
        if (acc) begin
          cmd.v_store = 1'b1;
          if (stat.v_done) state_nxt = S_V_CHK;
        end
      end
      S_V_CHK: begin
        if (acc) state_nxt = stat.v_chk_ok ? S_V_EOF : S_HUNT;
      end
      S_V_EOF: begin
        if (acc) begin
          cmd.emit_meas = stat.eof;
          state_nxt     = S_HUNT;
        end
      end
      S_R_CMD: begin
        if (acc) begin
          cmd.r_cmd = 1'b1;
          state_nxt = S_R_LEN;
        end
      end
      S_R_LEN: begin
        if (acc) begin
          cmd.r_len = 1'b1;
          priority if (stat.len_big) state_nxt = S_HUNT;
          else if (stat.rx_zero)     state_nxt = S_R_CHK;
          else                       state_nxt = S_R_DATA;
        end
      end
      S_R_DATA: begin
        if (acc) begin
          cmd.r_data = 1'b1;
          if (stat.r_done) state_nxt = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (acc) state_nxt = stat.r_chk_ok ? S_R_EOF : S_HUNT;
      end
      S_R_EOF: begin
        if (acc) begin
          state_nxt = S_HUNT;
          if (stat.eof) begin
            if (stat.len_zero) begin
              cmd.emit_zero = 1'b1;
            end else begin
              cmd.rd_start = 1'b1;
              state_nxt    = S_EMIT_RD;
            end
          end
        end
      end
      S_EMIT_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = stat.emit_last ? S_HUNT : S_EMIT_RD;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/dfl_dpath.sv
// ----------------------------------------------------------------------------
// dfl_dpath
// Frame field registers, checksums, payload store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfl_dpath
  import dfl_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_rx_byte,
  input  wire dfl_cmd_t   cmd,
  output dfl_stat_t       stat,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic            out_kind,
  output logic [15:0]     out_reading,
  output logic [7:0]      out_command,
  output logic [6:0]      out_length,
  output logic [5:0]      out_position,
  output logic [7:0]      out_data_byte,
  output logic            out_last
);

  localparam int PAYLOAD_LIMIT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;

  logic [7:0]          value_hi_r, value_lo_r;
  logic                value_count_r;
  logic [7:0]          resp_command_r;
  logic [6:0]          resp_length_r;
  logic [6:0]          resp_count_r;
  logic [7:0]          running_sum_r;
  logic [STORE_AW-1:0] rd_idx_r;
  logic [7:0]          ram_rdata;
  logic [6:0]          count_inc;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [15:0]         out_reading_r;
  logic [7:0]          out_command_r;
  logic [6:0]          out_length_r;
  logic [5:0]          out_position_r;
  logic [7:0]          out_data_byte_r;
  logic                out_last_r;

  assign count_inc = resp_count_r + 7'd1;

  always_comb begin
    stat.sof_v     = (in_rx_byte == SOF_VALUE);
    stat.sof_r     = (in_rx_byte == SOF_RESP);
    stat.eof       = (in_rx_byte == EOF_BYTE);
    stat.v_chk_ok  = (in_rx_byte == 8'(value_hi_r + value_lo_r));
    stat.v_done    = value_count_r;
    stat.len_big   = (in_rx_byte > 8'(PAYLOAD_LIMIT));
    stat.rx_zero   = (in_rx_byte == 8'd0);
    stat.r_done    = (count_inc >= resp_length_r);
    stat.r_chk_ok  = (in_rx_byte == running_sum_r);
    stat.len_zero  = (resp_length_r == 7'd0);
    stat.emit_last = (rd_idx_r == STORE_AW'(resp_length_r - 7'd1));
    stat.out_valid = out_valid_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_hi_r     <= '0;
      value_lo_r     <= '0;
      value_count_r  <= 1'b0;
      resp_command_r <= '0;
      resp_length_r  <= '0;
      resp_count_r   <= '0;
      running_sum_r  <= '0;
      rd_idx_r       <= '0;
    end else begin
      if (cmd.v_start) value_count_r <= 1'b0;
      if (cmd.v_store) begin
        if (value_count_r) value_lo_r <= in_rx_byte;
        else               value_hi_r <= in_rx_byte;
        value_count_r <= !value_count_r;
      end
      if (cmd.r_start) begin
        resp_count_r  <= '0;
        running_sum_r <= '0;
      end
      if (cmd.r_cmd) begin
        resp_command_r <= in_rx_byte;
        running_sum_r  <= in_rx_byte;
      end
      if (cmd.r_len) begin
        running_sum_r <= running_sum_r + in_rx_byte;
        resp_count_r  <= '0;
        if (!stat.len_big) resp_length_r <= in_rx_byte[6:0];
      end
      if (cmd.r_data) begin
        running_sum_r <= running_sum_r + in_rx_byte;
        resp_count_r  <= count_inc;
      end
      if (cmd.rd_start)  rd_idx_r <= '0;
      if (cmd.emit_load) rd_idx_r <= rd_idx_r + STORE_AW'(1);
    end
  end

  dfl_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.r_data),
    .waddr(resp_count_r[STORE_AW-1:0]),
    .wdata(in_rx_byte),
    .re   (cmd.rd_issue),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_meas || cmd.emit_zero || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields hold unless a load command is present
  always_ff @(posedge clk) begin
    if (cmd.emit_meas) begin
      out_kind_r      <= KIND_MEAS;
      out_reading_r   <= {value_hi_r, value_lo_r};
      out_command_r   <= '0;
      out_length_r    <= '0;
      out_position_r  <= '0;
      out_data_byte_r <= '0;
      out_last_r      <= 1'b1;
    end else if (cmd.emit_zero) begin
      out_kind_r      <= KIND_RESP;
      out_reading_r   <= '0;
      out_command_r   <= resp_command_r;
      out_length_r    <= '0;
      out_position_r  <= '0;
      out_data_byte_r <= '0;
      out_last_r      <= 1'b1;
    end else if (cmd.emit_load) begin
      out_kind_r      <= KIND_RESP;
      out_reading_r   <= '0;
      out_command_r   <= resp_command_r;
      out_length_r    <= resp_length_r;
      out_position_r  <= rd_idx_r;
      out_data_byte_r <= ram_rdata;
      out_last_r      <= stat.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_reading   = out_reading_r;
  assign out_command   = out_command_r;
  assign out_length    = out_length_r;
  assign out_position  = out_position_r;
  assign out_data_byte = out_data_byte_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/dual_frame_link_parser.sv
// ----------------------------------------------------------------------------
// dual_frame_link_parser
// Serial byte parser for measurement (0xAA) and response (0xB5) frames.
// ----------------------------------------------------------------------------
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid/in_ready   | in_rx_byte
//   out     | out_valid/out_ready | out_kind, out_reading, out_command,
//           |                     | out_length, out_position, out_data_byte,
//           |                     | out_last
//
// One byte per cycle while a frame is parsed. An end byte waits while the
// result register is full. A valid response frame with payload then holds
// the input while each payload byte is read from the store and loaded into
// the result register, and while out_ready stalls. Reset is synchronous,
// active low; the store needs no clearing: only current-frame bytes are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_frame_link_parser_defines.svh"

module dual_frame_link_parser
  import dfl_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_reading,
  output logic [7:0]       out_command,
  output logic [6:0]       out_length,
  output logic [5:0]       out_position,
  output logic [7:0]       out_data_byte,
  output logic             out_last
);

  dfl_cmd_t  cmd;
  dfl_stat_t stat;

  dfl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  dfl_dpath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_rx_byte   (in_rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_reading  (out_reading),
    .out_command  (out_command),
    .out_length   (out_length),
    .out_position (out_position),
    .out_data_byte(out_data_byte),
    .out_last     (out_last)
  );

  `DFL_ASSERT_NOW(a_emit_into_empty, clk, rst_n, cmd.emit_meas || cmd.emit_zero, !out_valid, "frame result loaded over a pending request")
  `DFL_ASSERT_NOW(a_emit_holds_input, clk, rst_n, cmd.rd_issue || cmd.emit_load, !in_ready, "input taken during payload run")
  `DFL_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.emit_load || cmd.emit_meas || cmd.emit_zero, out_valid, "loaded result not presented")

endmodule

`default_nettype wire
